>>> sv/dqne_pkg.sv
// ---------------------------------------------------------------------------
// DNS question name encoder package
// Item types, configuration record and constants shared by the encoder.
// ---------------------------------------------------------------------------
package dqne_pkg;

    localparam int MAX_LABEL = 63;
    localparam int LEN_W     = $clog2(MAX_LABEL + 1);
    localparam int ADDR_W    = $clog2(MAX_LABEL);
    // byte positions of one question: length, label, terminator, type, class
    localparam int POS_W     = $clog2(MAX_LABEL + 8);
    localparam int PADDR_W   = 3;

    localparam logic [7:0] DOT_CHAR = 8'd46;

    // register select, taken from the word address bit
    localparam logic REG_QUERY_TYPE  = 1'b0;
    localparam logic REG_QUERY_CLASS = 1'b1;

    localparam logic [15:0] QUERY_TYPE_RST  = 16'd1;
    localparam logic [15:0] QUERY_CLASS_RST = 16'd1;

    typedef struct packed {
        logic [7:0] name_char;
        logic       name_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       second_present;
        logic       run_last;
        logic       question_done;
        logic       label_truncated;
    } t_out_item;

    typedef struct packed {
        logic [15:0] query_type;
        logic [15:0] query_class;
    } t_cfg;

endpackage

>>> sv/dqne_label_ram.sv
// ---------------------------------------------------------------------------
// Label store
// One write port, two registered read ports with a shared read enable.
// ---------------------------------------------------------------------------
module dqne_label_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [dqne_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                  i_wdata,
    input  logic                        i_re,
    input  logic [dqne_pkg::ADDR_W-1:0] i_raddr0,
    input  logic [dqne_pkg::ADDR_W-1:0] i_raddr1,
    output logic [7:0]                  o_rdata0,
    output logic [7:0]                  o_rdata1
);

    logic [7:0] mem [0:dqne_pkg::MAX_LABEL-1];
    logic [7:0] r_rdata0;
    logic [7:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data while the read side is frozen
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= mem[i_raddr0];
            r_rdata1 <= mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

>>> sv/dqne_cfg_regs.sv
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style access to the query type and query class words.
// ---------------------------------------------------------------------------
module dqne_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dqne_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output dqne_pkg::t_cfg               o_cfg
);

    logic [15:0] r_query_type;
    logic [15:0] r_query_class;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_type  <= dqne_pkg::QUERY_TYPE_RST;
            r_query_class <= dqne_pkg::QUERY_CLASS_RST;
        end else if (wr_en) begin
            case (paddr[2])
                dqne_pkg::REG_QUERY_TYPE:  r_query_type  <= pwdata[15:0];
                dqne_pkg::REG_QUERY_CLASS: r_query_class <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dqne_pkg::REG_QUERY_TYPE:  prdata = {16'd0, r_query_type};
            dqne_pkg::REG_QUERY_CLASS: prdata = {16'd0, r_query_class};
            default:                   prdata = 32'd0;
        endcase
    end

    assign o_cfg.query_type  = r_query_type;
    assign o_cfg.query_class = r_query_class;

endmodule

>>> sv/dns_question_name_encoder_unit.sv
// ---------------------------------------------------------------------------
// DNS question name encoder
// Collects host name characters into a label store and emits the encoded
// question (length-prefixed labels, terminator, type, class) up to two bytes
// per result transfer.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       in         i_in_valid / o_in_stall   i_in_item  (t_in_item)
//  out      out        o_out_valid / i_out_stall o_out_item (t_out_item)
//  cfg      in         APB psel/penable/pready   paddr, pwdata, prdata
//
//  A character is absorbed and written to the label store unless it is full.
//  A dot after a non-empty label, or an end mark, starts a drain, the store
//  read two bytes per cycle through its two read ports unless the output
//  stalls; the input stalls for the drain. Results pass a read stage and an
//  output register. Reset is synchronous; the label store needs no clearing.
//  An output stall freezes the drain, the read stage and the output register.
// ---------------------------------------------------------------------------
module dns_question_name_encoder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  dqne_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output dqne_pkg::t_out_item          o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dqne_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int LW = dqne_pkg::LEN_W;
    localparam int PW = dqne_pkg::POS_W;
    localparam int AW = dqne_pkg::ADDR_W;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    // flush descriptor carried along with each result slot
    typedef struct packed {
        logic [LW-1:0] len;
        logic          name_end;
        logic          trunc;
        logic [PW-1:0] total;
    } t_flush;

    dqne_pkg::t_cfg      cfg;
    t_state              r_state, n_state;
    logic [LW-1:0]       r_label_len, n_label_len;
    logic                r_overflow, n_overflow;
    logic [PW-1:0]       r_pos, n_pos;
    t_flush              r_flush, n_flush;
    logic                r_b_valid;
    logic [PW-1:0]       r_b_pos;
    t_flush              r_b_flush;
    logic                r_out_valid;
    dqne_pkg::t_out_item r_out, n_out;

    logic                in_acc;
    logic                advance;
    logic                is_char;
    logic                store_we;
    logic [AW-1:0]       raddr0, raddr1;
    logic [7:0]          rdata0, rdata1;
    logic [PW-1:0]       b_pos1;

    dqne_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // store index for byte k of the stream; byte 0 is the length byte of a non-empty label
    function automatic logic [AW-1:0] rd_addr(input logic [PW-1:0] k,
                                              input logic [LW-1:0] len);
        logic [PW-1:0] idx;
        idx = k - PW'(1);
        if (k != '0 && k <= PW'(len)) begin
            rd_addr = idx[AW-1:0];
        end else begin
            rd_addr = '0;
        end
    endfunction

    function automatic logic [7:0] form_byte(input logic [PW-1:0] k,
                                             input t_flush fl,
                                             input logic [7:0] rd,
                                             input dqne_pkg::t_cfg c);
        logic [PW-1:0] hdr;
        logic [PW-1:0] t;
        hdr = (fl.len != '0) ? PW'(fl.len) + PW'(1) : '0;
        t   = k - hdr;
        form_byte = 8'd0;
        if (fl.len != '0 && k == '0) begin
            form_byte = 8'(fl.len);
        end else if (k < hdr) begin
            form_byte = rd;
        end else begin
            case (t)
                PW'(1):  form_byte = c.query_type[15:8];
                PW'(2):  form_byte = c.query_type[7:0];
                PW'(3):  form_byte = c.query_class[15:8];
                PW'(4):  form_byte = c.query_class[7:0];
                default: form_byte = 8'd0;
            endcase
        end
    endfunction

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign advance    = !r_out_valid || !i_out_stall;
    assign is_char    = !i_in_item.name_end && (i_in_item.name_char != dqne_pkg::DOT_CHAR);
    assign store_we   = in_acc && is_char && (r_label_len < LW'(dqne_pkg::MAX_LABEL));

    assign raddr0 = rd_addr(r_pos, r_flush.len);
    assign raddr1 = rd_addr(r_pos + PW'(1), r_flush.len);

    dqne_label_ram u_ram (
        .i_clk    (i_clk),
        .i_we     (store_we),
        .i_waddr  (r_label_len[AW-1:0]),
        .i_wdata  (i_in_item.name_char),
        .i_re     (advance && (r_state == ST_DRAIN)),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

    // sequencer: absorb characters, then walk the byte stream two at a time
    always_comb begin
        n_state     = r_state;
        n_label_len = r_label_len;
        n_overflow  = r_overflow;
        n_pos       = r_pos;
        n_flush     = r_flush;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (is_char) begin
                        if (store_we) begin
                            n_label_len = r_label_len + LW'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end else if (i_in_item.name_end || r_label_len != '0) begin
                        n_flush.len      = r_label_len;
                        n_flush.name_end = i_in_item.name_end;
                        n_flush.trunc    = r_overflow;
                        n_flush.total    = ((r_label_len != '0) ?
                                            PW'(r_label_len) + PW'(1) : '0)
                                         + (i_in_item.name_end ? PW'(5) : '0);
                        n_pos       = '0;
                        n_label_len = '0;
                        n_overflow  = 1'b0;
                        n_state     = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (advance) begin
                    n_pos = r_pos + PW'(2);
                    if (r_pos + PW'(2) >= r_flush.total) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign b_pos1 = r_b_pos + PW'(1);

    always_comb begin
        n_out.first_byte      = form_byte(r_b_pos, r_b_flush, rdata0, cfg);
        n_out.second_present  = b_pos1 < r_b_flush.total;
        n_out.second_byte     = n_out.second_present ?
                                form_byte(b_pos1, r_b_flush, rdata1, cfg) : 8'd0;
        n_out.run_last        = (r_b_pos + PW'(2)) >= r_b_flush.total;
        n_out.question_done   = r_b_flush.name_end && n_out.run_last;
        n_out.label_truncated = r_b_flush.trunc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_label_len <= '0;
            r_overflow  <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_label_len <= n_label_len;
            r_overflow  <= n_overflow;
            if (advance) begin
                r_b_valid   <= (r_state == ST_DRAIN);
                r_out_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_flush <= n_flush;
        if (advance) begin
            r_b_pos   <= r_pos;
            r_b_flush <= r_flush;
            r_out     <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
